// ===== hw/rtl/dwm_pkg.sv =====
package dwm_pkg;

  // Configuration register width and default values
  localparam int CFG_W           = 24;
  localparam int DEF_TIME_BITS   = 32;
  localparam int DEF_TIMER_BITS  = 24;
  localparam logic [CFG_W-1:0] MIN_DEADLINE_RST = 24'd0;
  localparam logic [CFG_W-1:0] MAX_DEADLINE_RST = 24'd1000;

  // Configuration register indexes
  localparam logic REG_MIN_DEADLINE = 1'b0;
  localparam logic REG_MAX_DEADLINE = 1'b1;

  // Item kinds carried in the input tuser
  localparam logic [1:0] FUNC_SOURCE = 2'd0;
  localparam logic [1:0] FUNC_TARGET = 2'd1;
  localparam logic [1:0] FUNC_OTHER  = 2'd2;
  localparam logic [1:0] FUNC_TICK   = 2'd3;

  // Deadline window as seen by the checker core
  typedef struct packed {
    logic [CFG_W-1:0] min_ms;
    logic [CFG_W-1:0] max_ms;
  } dwm_cfg_t;

endpackage

// ===== hw/rtl/deadline_window_monitor.sv =====
// Channel  Dir  Words
// in_      in   tuser[1:0] kind, tdata event time in ms
// out_     out  tdata[0] verdict (1 = incorrect), tuser[0] timer expiry
// cfg_     in   write only: index 0 min deadline, index 1 max deadline
//
// One word per cycle sustained while out_tready is high; a word passes the
// input register, then the output register. Kinds with no result (a tick
// without expiry, target while disarmed) leave nothing on the output. Reset
// is synchronous: monitor disarmed, timer stopped, status correct. A stall
// on out_tready holds the result register and backs up into in_tready.
module deadline_window_monitor
  import dwm_pkg::*;
#(
  parameter int TIME_BITS  = DEF_TIME_BITS,
  parameter int TIMER_BITS = DEF_TIMER_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // tdata: event_time_ms
  input  logic [((TIME_BITS + 7) / 8) * 8-1:0] in_tdata,
  // tuser: func
  input  logic [1:0]                          in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata: verdict, zero padded
  output logic [7:0]                          out_tdata,
  // tuser: from_timeout
  output logic                                out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_addr,
  input  logic [CFG_W-1:0]                    cfg_wr_data
);

  dwm_cfg_t             cfg;
  logic                 s1_valid_r;
  logic [1:0]           s1_func_r;
  logic [TIME_BITS-1:0] s1_time_r;
  logic                 take;
  logic                 verdict;

  dwm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  // Input register
  assign in_tready = !s1_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_func_r <= in_tuser;
      s1_time_r <= in_tdata[TIME_BITS-1:0];
    end
  end

  dwm_core #(
    .TIME_BITS  (TIME_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .item_valid  (s1_valid_r),
    .item_func   (s1_func_r),
    .item_time   (s1_time_r),
    .item_take   (take),
    .res_valid   (out_tvalid),
    .res_verdict (verdict),
    .res_timeout (out_tuser),
    .res_ready   (out_tready)
  );

  assign out_tdata = {7'd0, verdict};

`ifndef SYNTHESIS
  // Expiry reports are always incorrect
  a_timeout_incorrect: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[0])
    else $error("timer expiry reported as correct");

  // A new result only follows a staged word
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_valid_r))
    else $error("result without staged word");

  // Staged word is consumed whenever the result slot is free
  a_stage_drain: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && (!out_tvalid || out_tready) |-> take)
    else $error("staged word not consumed");
`endif

endmodule

// ===== hw/rtl/dwm_cfg.sv =====
module dwm_cfg
  import dwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_wr_data,
  output dwm_cfg_t         cfg
);

  logic [CFG_W-1:0] min_r;
  logic [CFG_W-1:0] max_r;

  // Register file, write only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_DEADLINE_RST;
      max_r <= MAX_DEADLINE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_MIN_DEADLINE: min_r <= cfg_wr_data;
        REG_MAX_DEADLINE: max_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  assign cfg.min_ms = min_r;
  assign cfg.max_ms = max_r;

endmodule

// ===== hw/rtl/dwm_core.sv =====
module dwm_core
  import dwm_pkg::*;
#(
  parameter int TIME_BITS  = DEF_TIME_BITS,
  parameter int TIMER_BITS = DEF_TIMER_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dwm_cfg_t             cfg,
  // staged word from the input register
  input  logic                 item_valid,
  input  logic [1:0]           item_func,
  input  logic [TIME_BITS-1:0] item_time,
  output logic                 item_take,
  // result register
  output logic                 res_valid,
  output logic                 res_verdict,
  output logic                 res_timeout,
  input  logic                 res_ready
);

  localparam int DW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam int EW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  logic                  armed_r,   armed_nxt;
  logic [TIME_BITS-1:0]  src_time_r, src_time_nxt;
  logic                  run_r,     run_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic                  status_r,  status_nxt;
  logic                  res_valid_r, res_verdict_r, res_timeout_r;

  logic                  has_res;
  logic                  res_v, res_t;
  logic [TIME_BITS-1:0]  diff;
  logic [DW-1:0]         diff_ext;
  logic [TIMER_BITS-1:0] elapsed_inc;
  logic                  elapsed_sat;
  logic                  expired;

  // Result slot frees when empty or being drained this cycle
  assign item_take = item_valid && (!res_valid_r || res_ready);

  // Window and timer arithmetic
  assign diff        = item_time - src_time_r;
  assign diff_ext    = DW'(diff);
  assign elapsed_sat = (elapsed_r == {TIMER_BITS{1'b1}});
  assign elapsed_inc = elapsed_sat ? elapsed_r : elapsed_r + TIMER_BITS'(1);
  assign expired     = (EW'(elapsed_inc) >= EW'(cfg.max_ms)) ||
                       (elapsed_inc == {TIMER_BITS{1'b1}});

  // Per-item state update and result
  always_comb begin
    armed_nxt    = armed_r;
    src_time_nxt = src_time_r;
    run_nxt      = run_r;
    elapsed_nxt  = elapsed_r;
    status_nxt   = status_r;
    has_res      = 1'b0;
    res_v        = status_r;
    res_t        = 1'b0;
    if (item_take) begin
      unique case (item_func)
        FUNC_SOURCE: begin
          if (armed_r) begin
            status_nxt = 1'b1;
          end else begin
            status_nxt  = 1'b0;
            run_nxt     = 1'b1;
            elapsed_nxt = '0;
          end
          armed_nxt    = 1'b1;
          src_time_nxt = item_time;
          has_res      = 1'b1;
          res_v        = status_nxt;
        end
        FUNC_TARGET: begin
          run_nxt = 1'b0;
          if (armed_r) begin
            status_nxt   = (diff_ext < DW'(cfg.min_ms)) || (diff_ext > DW'(cfg.max_ms));
            armed_nxt    = 1'b0;
            src_time_nxt = '0;
            has_res      = 1'b1;
            res_v        = status_nxt;
          end
        end
        FUNC_OTHER: begin
          has_res = 1'b1;
        end
        FUNC_TICK: begin
          if (run_r) begin
            elapsed_nxt = elapsed_inc;
            if (expired) begin
              run_nxt      = 1'b0;
              status_nxt   = 1'b1;
              armed_nxt    = 1'b0;
              src_time_nxt = '0;
              has_res      = 1'b1;
              res_v        = 1'b1;
              res_t        = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Supervision state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r    <= 1'b0;
      src_time_r <= '0;
      run_r      <= 1'b0;
      elapsed_r  <= '0;
      status_r   <= 1'b0;
    end else begin
      armed_r    <= armed_nxt;
      src_time_r <= src_time_nxt;
      run_r      <= run_nxt;
      elapsed_r  <= elapsed_nxt;
      status_r   <= status_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (item_take && has_res) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && has_res) begin
      res_verdict_r <= res_v;
      res_timeout_r <= res_t;
    end
  end

  assign res_valid   = res_valid_r;
  assign res_verdict = res_verdict_r;
  assign res_timeout = res_timeout_r;

endmodule
